>>> rtl/sbpc_pkg.sv
// ----------------------------------------------------------------------------
// sbpc_pkg: shared types and constants for the servo bus packet checker
// Holds the parser phase encoding, the result record and register constants.
// ----------------------------------------------------------------------------
package sbpc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register index bit of the byte address
	localparam int unsigned REG_IDX_BIT = 2;

	localparam logic REG_HEADER_BYTE = 1'b0;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hFF;
	localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd2;

	typedef enum logic [2:0] {
		PH_HEAD1 = 3'd0,
		PH_HEAD2 = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_ERR   = 3'd4,
		PH_PARAM = 3'd5,
		PH_SUM   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] error_code;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] data_index;
		logic              is_last;
		logic              checksum_ok;
	} result_t;

endpackage

>>> rtl/servo_bus_packet_checker.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_checker: servo bus status packet parser and checksum check
// Frames received bytes into packets and reports parameters and the verdict.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while in_stall is low. Each parameter byte
// comes out as a result with its index, and the checksum byte (or a length
// below two) closes the packet with is_last high. Results reach the output
// from a result register; a second register catches one more result while
// the output is stalled, and in_stall rises only while that second register
// is full. Header bytes, id, error bytes and length bytes of two or more give
// no result. The header value is set through the APB register at byte
// address 0 (reset 0xFF).
module servo_bus_packet_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbpc_pkg::PADDR_W-1:0]     paddr,
	input  logic [sbpc_pkg::PDATA_W-1:0]     pwdata,
	output logic [sbpc_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sbpc_pkg::BYTE_W-1:0]      rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sbpc_pkg::BYTE_W-1:0]      frame_id,
	output logic [sbpc_pkg::BYTE_W-1:0]      error_code,
	output logic [sbpc_pkg::BYTE_W-1:0]      data_byte,
	output logic [sbpc_pkg::BYTE_W-1:0]      data_index,
	output logic                             is_last,
	output logic                             checksum_ok
);

	logic [sbpc_pkg::BYTE_W-1:0] header_byte;
	logic                        accept;
	logic                        res_valid;
	sbpc_pkg::result_t           res;
	sbpc_pkg::result_t           out_res;

	assign accept = in_valid & ~in_stall;

	sbpc_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.header_byte (header_byte)
	);

	sbpc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.header_byte (header_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	sbpc_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign frame_id    = out_res.frame_id;
	assign error_code  = out_res.error_code;
	assign data_byte   = out_res.data_byte;
	assign data_index  = out_res.data_index;
	assign is_last     = out_res.is_last;
	assign checksum_ok = out_res.checksum_ok;

endmodule

>>> rtl/sbpc_apb_regs.sv
// ----------------------------------------------------------------------------
// sbpc_apb_regs: configuration register file
// APB slave holding the header byte value; always ready, no wait states.
// ----------------------------------------------------------------------------
module sbpc_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbpc_pkg::PADDR_W-1:0]     paddr,
	input  logic [sbpc_pkg::PDATA_W-1:0]     pwdata,
	output logic [sbpc_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	output logic [sbpc_pkg::BYTE_W-1:0]      header_byte
);

	logic [sbpc_pkg::BYTE_W-1:0] header_q;
	logic                        reg_sel;
	logic                        wr_en;

	assign reg_sel = (paddr[sbpc_pkg::REG_IDX_BIT] == sbpc_pkg::REG_HEADER_BYTE);
	assign wr_en   = psel & penable & pwrite & reg_sel;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= sbpc_pkg::HEADER_RESET;
		end else if (wr_en) begin
			header_q <= pwdata[sbpc_pkg::BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[sbpc_pkg::BYTE_W-1:0] = header_q;
		end
	end

	assign header_byte = header_q;

endmodule

>>> rtl/sbpc_parser.sv
// ----------------------------------------------------------------------------
// sbpc_parser: packet framing and checksum state
// Walks header, id, length, error, parameter and checksum bytes, one per beat.
// ----------------------------------------------------------------------------
module sbpc_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [sbpc_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [sbpc_pkg::BYTE_W-1:0]  header_byte,
	output logic                         res_valid,
	output sbpc_pkg::result_t            res
);

	sbpc_pkg::phase_t            phase_q, phase_d;
	logic [sbpc_pkg::BYTE_W-1:0] id_q, id_d;
	logic [sbpc_pkg::BYTE_W-1:0] left_q, left_d;
	logic [sbpc_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic [sbpc_pkg::BYTE_W-1:0] err_q, err_d;
	logic [sbpc_pkg::BYTE_W-1:0] count_q, count_d;
	logic [sbpc_pkg::BYTE_W-1:0] left_dec;
	logic [sbpc_pkg::BYTE_W-1:0] sum_add;
	logic                        emit;

	assign left_dec = left_q - 8'd1;
	assign sum_add  = sum_q + rx_byte;

	// next state
	always_comb begin
		phase_d = phase_q;
		id_d    = id_q;
		left_d  = left_q;
		sum_d   = sum_q;
		err_d   = err_q;
		count_d = count_q;
		case (phase_q)
			sbpc_pkg::PH_HEAD2: begin
				phase_d = (rx_byte == header_byte) ? sbpc_pkg::PH_ID : sbpc_pkg::PH_HEAD1;
			end
			sbpc_pkg::PH_ID: begin
				id_d    = rx_byte;
				sum_d   = rx_byte;
				phase_d = sbpc_pkg::PH_LEN;
			end
			sbpc_pkg::PH_LEN: begin
				if (rx_byte < sbpc_pkg::MIN_LENGTH) begin
					err_d   = '0;
					phase_d = sbpc_pkg::PH_HEAD1;
				end else begin
					sum_d   = sum_add;
					left_d  = rx_byte - sbpc_pkg::MIN_LENGTH;
					phase_d = sbpc_pkg::PH_ERR;
				end
			end
			sbpc_pkg::PH_ERR: begin
				err_d   = rx_byte;
				sum_d   = sum_add;
				count_d = '0;
				phase_d = (left_q == '0) ? sbpc_pkg::PH_SUM : sbpc_pkg::PH_PARAM;
			end
			sbpc_pkg::PH_PARAM: begin
				sum_d   = sum_add;
				count_d = count_q + 8'd1;
				left_d  = left_dec;
				if (left_dec == '0) begin
					phase_d = sbpc_pkg::PH_SUM;
				end
			end
			sbpc_pkg::PH_SUM: begin
				phase_d = sbpc_pkg::PH_HEAD1;
			end
			default: begin
				// first header hunt, also recovers from unused codes
				phase_d = (rx_byte == header_byte) ? sbpc_pkg::PH_HEAD2 : sbpc_pkg::PH_HEAD1;
			end
		endcase
	end

	// result for this beat
	always_comb begin
		emit            = 1'b0;
		res.frame_id    = id_q;
		res.error_code  = err_q;
		res.data_byte   = '0;
		res.data_index  = '0;
		res.is_last     = 1'b0;
		res.checksum_ok = 1'b0;
		case (phase_q)
			sbpc_pkg::PH_LEN: begin
				// short length: broken packet closes at once
				emit           = (rx_byte < sbpc_pkg::MIN_LENGTH);
				res.error_code = '0;
				res.is_last    = 1'b1;
			end
			sbpc_pkg::PH_PARAM: begin
				emit           = 1'b1;
				res.data_byte  = rx_byte;
				res.data_index = count_q;
			end
			sbpc_pkg::PH_SUM: begin
				emit            = 1'b1;
				res.is_last     = 1'b1;
				res.checksum_ok = (~sum_q == rx_byte);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign res_valid = accept & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbpc_pkg::PH_HEAD1;
			id_q    <= '0;
			left_q  <= '0;
			sum_q   <= '0;
			err_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			id_q    <= id_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			err_q   <= err_d;
			count_q <= count_d;
		end
	end

endmodule

>>> rtl/sbpc_out_skid.sv
// ----------------------------------------------------------------------------
// sbpc_out_skid: result register with skid stage
// Holds results for the output channel; input stall comes from a register.
// ----------------------------------------------------------------------------
module sbpc_out_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  sbpc_pkg::result_t  res,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output sbpc_pkg::result_t  out_res
);

	logic              main_valid_q;
	logic              skid_valid_q;
	sbpc_pkg::result_t main_q;
	sbpc_pkg::result_t skid_q;
	logic              take;

	assign take = main_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			// skid is empty whenever a beat is taken in
			if (!main_valid_q || take) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			if (!main_valid_q || take) begin
				main_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (take && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

endmodule

>>> verif/servo_bus_packet_checker_tb.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_checker_tb: self-checking bench for the status packet parser
// Streams framed and broken packets under several header values, predicts each
// parameter and closing beat in a local parser copy and compares every field.
// ----------------------------------------------------------------------------
module servo_bus_packet_checker_tb;

	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_BYTES  = 300;
	localparam logic [sbpc_pkg::PADDR_W-1:0] HEADER_ADDR =
		{{(sbpc_pkg::PADDR_W-1){1'b0}}, sbpc_pkg::REG_HEADER_BYTE} << sbpc_pkg::REG_IDX_BIT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [sbpc_pkg::PADDR_W-1:0] paddr = '0;
	logic [sbpc_pkg::PDATA_W-1:0] pwdata = '0;
	logic [sbpc_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [sbpc_pkg::BYTE_W-1:0] rx_byte = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [sbpc_pkg::BYTE_W-1:0] frame_id;
	logic [sbpc_pkg::BYTE_W-1:0] error_code;
	logic [sbpc_pkg::BYTE_W-1:0] data_byte;
	logic [sbpc_pkg::BYTE_W-1:0] data_index;
	logic                        is_last;
	logic                        checksum_ok;

	servo_bus_packet_checker uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_id    (frame_id),
		.error_code  (error_code),
		.data_byte   (data_byte),
		.data_index  (data_index),
		.is_last     (is_last),
		.checksum_ok (checksum_ok)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// parser copy used for prediction
	logic [sbpc_pkg::BYTE_W-1:0] hdr_value = sbpc_pkg::HEADER_RESET;
	sbpc_pkg::phase_t            parse_ph = sbpc_pkg::PH_HEAD1;
	logic [sbpc_pkg::BYTE_W-1:0] pk_id = '0;
	logic [sbpc_pkg::BYTE_W-1:0] pk_err = '0;
	logic [sbpc_pkg::BYTE_W-1:0] pk_left = '0;
	logic [sbpc_pkg::BYTE_W-1:0] pk_sum = '0;
	logic [sbpc_pkg::BYTE_W-1:0] pk_nparam = '0;

	logic [sbpc_pkg::BYTE_W-1:0] rx_bytes_q[$];
	sbpc_pkg::result_t           pending_results[$];
	int                          fails = 0;
	bit                          idling_on = 1'b1;
	int unsigned                 in_gap = 0;
	int unsigned                 out_hold = 0;

	function automatic void parse_byte(input logic [sbpc_pkg::BYTE_W-1:0] b);
		sbpc_pkg::result_t r;
		r = '0;
		r.frame_id = pk_id;
		case (parse_ph)
			sbpc_pkg::PH_HEAD2:
				parse_ph = (b == hdr_value) ? sbpc_pkg::PH_ID : sbpc_pkg::PH_HEAD1;
			sbpc_pkg::PH_ID: begin
				pk_id = b;
				pk_sum = b;
				parse_ph = sbpc_pkg::PH_LEN;
			end
			sbpc_pkg::PH_LEN: begin
				if (b < sbpc_pkg::MIN_LENGTH) begin
					pk_err = '0;
					parse_ph = sbpc_pkg::PH_HEAD1;
					r.is_last = 1'b1;
					pending_results.push_back(r);
				end else begin
					pk_sum = pk_sum + b;
					pk_left = b - sbpc_pkg::MIN_LENGTH;
					parse_ph = sbpc_pkg::PH_ERR;
				end
			end
			sbpc_pkg::PH_ERR: begin
				pk_err = b;
				pk_sum = pk_sum + b;
				pk_nparam = '0;
				parse_ph = (pk_left == 0) ? sbpc_pkg::PH_SUM : sbpc_pkg::PH_PARAM;
			end
			sbpc_pkg::PH_PARAM: begin
				r.error_code = pk_err;
				r.data_byte = b;
				r.data_index = pk_nparam;
				pk_sum = pk_sum + b;
				pk_nparam = pk_nparam + 1'b1;
				pk_left = pk_left - 1'b1;
				if (pk_left == 0)
					parse_ph = sbpc_pkg::PH_SUM;
				pending_results.push_back(r);
			end
			sbpc_pkg::PH_SUM: begin
				r.error_code = pk_err;
				r.is_last = 1'b1;
				r.checksum_ok = (~pk_sum) == b;
				parse_ph = sbpc_pkg::PH_HEAD1;
				pending_results.push_back(r);
			end
			default:
				parse_ph = (b == hdr_value) ? sbpc_pkg::PH_HEAD2 : sbpc_pkg::PH_HEAD1;
		endcase
	endfunction

	// byte driver: valid is held until the beat is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap = in_gap - 1;
				end else if (rx_bytes_q.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte <= rx_bytes_q.pop_front();
					if (idling_on && $urandom_range(0, 4) == 0)
						in_gap = $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk) begin
		sbpc_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result beat: frame_id %0h is_last %0b", frame_id, is_last);
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (frame_id !== want.frame_id) begin
						$error("frame_id: expected %0h, actual %0h", want.frame_id, frame_id);
						fails++;
					end
					if (error_code !== want.error_code) begin
						$error("error_code: expected %0h, actual %0h", want.error_code, error_code);
						fails++;
					end
					if (data_byte !== want.data_byte) begin
						$error("data_byte: expected %0h, actual %0h", want.data_byte, data_byte);
						fails++;
					end
					if (data_index !== want.data_index) begin
						$error("data_index: expected %0d, actual %0d", want.data_index, data_index);
						fails++;
					end
					if (is_last !== want.is_last) begin
						$error("is_last: expected %0b, actual %0b", want.is_last, is_last);
						fails++;
					end
					if (checksum_ok !== want.checksum_ok) begin
						$error("checksum_ok: expected %0b, actual %0b", want.checksum_ok,
							checksum_ok);
						fails++;
					end
				end
			end
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold = out_hold - 1;
			end else begin
				out_stall <= 1'b0;
				if (idling_on && $urandom_range(0, 5) == 0)
					out_hold = $urandom_range(1, 4);
			end
		end
	end

	task automatic wait_idle();
		while (rx_bytes_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write the header register, then read it back
	task automatic set_header(input logic [sbpc_pkg::BYTE_W-1:0] val);
		logic [sbpc_pkg::PDATA_W-1:0] word;
		word = '0;
		word[sbpc_pkg::BYTE_W-1:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= HEADER_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		hdr_value = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== word) begin
			$error("header_byte readback: expected %0h, actual %0h", val, prdata);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_packet(input logic [sbpc_pkg::BYTE_W-1:0] hdr,
		input logic [sbpc_pkg::BYTE_W-1:0] len);
		logic [sbpc_pkg::BYTE_W-1:0] id;
		logic [sbpc_pkg::BYTE_W-1:0] sum;
		logic [sbpc_pkg::BYTE_W-1:0] b;
		int unsigned                 mode;
		id = 8'($urandom);
		rx_bytes_q.push_back(hdr);
		rx_bytes_q.push_back(hdr);
		rx_bytes_q.push_back(id);
		rx_bytes_q.push_back(len);
		if (len < sbpc_pkg::MIN_LENGTH)
			return;
		sum = id + len;
		for (int i = 0; i < len - 1; i++) begin
			// first beat here is the error byte, the rest are parameters
			b = 8'($urandom);
			sum = sum + b;
			rx_bytes_q.push_back(b);
		end
		mode = $urandom_range(0, 9);
		if (mode < 7)
			rx_bytes_q.push_back(~sum);
		else if (mode < 9)
			rx_bytes_q.push_back(~sum ^ (8'h01 << $urandom_range(0, 7)));
		else
			rx_bytes_q.push_back(8'($urandom));
	endtask

	initial begin
		logic [sbpc_pkg::BYTE_W-1:0] hdr_set[4];
		logic [sbpc_pkg::BYTE_W-1:0] len;
		int unsigned                 pick;
		int unsigned                 keep;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: second header mismatch, length two, lengths zero and one,
		// extreme parameters with a bad checksum
		rx_bytes_q = '{8'hFF, 8'h00,
			8'hFF, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'hFE,
			8'hFF, 8'hFF, 8'hFF, 8'h00,
			8'hFF, 8'hFF, 8'h7E, 8'h01,
			8'hFF, 8'hFF, 8'hFF, 8'h04, 8'h00, 8'h00, 8'hFF, 8'h00};

		hdr_set[0] = 8'h00;
		hdr_set[1] = 8'($urandom_range(1, 254));
		hdr_set[2] = 8'hFF;
		hdr_set[3] = 8'($urandom_range(1, 254));

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			set_header(hdr_set[p]);
			idling_on = (p != 3);
			if (p == 1)
				queue_packet(hdr_set[p], 8'd255);
			while (rx_bytes_q.size() < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					len = 8'($urandom_range(0, 1));
				else if (pick < 85)
					len = 8'($urandom_range(2, 12));
				else
					len = 8'($urandom_range(13, 60));
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					queue_packet(hdr_set[p], len);
				end else if (pick < 88) begin
					repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(8'($urandom));
				end else if (pick < 94) begin
					rx_bytes_q.push_back(hdr_set[p]);
					rx_bytes_q.push_back(hdr_set[p] ^ 8'($urandom_range(1, 255)));
				end else begin
					// packet cut short, the next header lands mid-packet
					keep = rx_bytes_q.size() + $urandom_range(3, 6);
					queue_packet(hdr_set[p], len | 8'h02);
					while (rx_bytes_q.size() > keep)
						void'(rx_bytes_q.pop_back());
				end
			end
		end

		wait_idle();
		if (fails == 0 && pending_results.size() == 0) begin
			$display("servo_bus_packet_checker: match");
		end else begin
			$display("servo_bus_packet_checker: mismatch");
		end
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("servo_bus_packet_checker: mismatch");
		$finish;
	end

endmodule
